[rtl/core/cghs_pkg.sv]
// ----------------------------------------------------------------------------
// cghs_pkg - shared types and constants of the channel gain / high-pass scaler
// Payload structs, register indexes, fixed-point widths and MAC control.
// ----------------------------------------------------------------------------
package cghs_pkg;

    localparam int CHANNELS_DEFAULT = 512;
    localparam int CH_W             = 9;
    localparam int DATA_W           = 32;
    localparam int DECAY_W          = 24;
    localparam int FRAC_BITS        = 24;
    localparam int VALUE_W          = 64;
    localparam int MUL_W            = 33;
    localparam int PROD_W           = 2 * MUL_W;
    localparam int ACC_W            = 96;
    localparam int CFG_IDX_W        = 2;

    localparam logic [DECAY_W-1:0] DECAY_RESET = 24'd16777000;
    localparam int MAX16 = (1 << 15) - 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HP_ENABLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MODE = 2'd2;

    // item opcodes
    localparam logic OP_GAIN   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // output width modes
    localparam logic MODE_16 = 1'b0;
    localparam logic MODE_32 = 1'b1;

    typedef struct packed {
        logic                     op;
        logic [CH_W-1:0]          channel;
        logic signed [DATA_W-1:0] sample_value;
        logic signed [DATA_W-1:0] gain_value;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0]          result_channel;
        logic signed [DATA_W-1:0] result_value;
    } out_item_t;

    // issued together with a multiplication, applied when its product lands
    typedef struct packed {
        logic acc_load;
        logic acc_add;
        logic shift32;
    } mac_ctrl_t;

endpackage

[rtl/core/cghs_mac.sv]
// ----------------------------------------------------------------------------
// cghs_mac - shared multiply-accumulate unit
// Registered 33x33 signed multiply followed by a 96-bit accumulate stage.
// ----------------------------------------------------------------------------
module cghs_mac (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic signed [cghs_pkg::MUL_W-1:0]     op_a,
    input  logic signed [cghs_pkg::MUL_W-1:0]     op_b,
    input  cghs_pkg::mac_ctrl_t                   ctrl,
    output logic signed [cghs_pkg::PROD_W-1:0]    prod,
    output logic signed [cghs_pkg::ACC_W-1:0]     acc
);

    logic signed [cghs_pkg::PROD_W-1:0] prod_reg;
    logic signed [cghs_pkg::ACC_W-1:0]  acc_reg;
    logic signed [cghs_pkg::ACC_W-1:0]  acc_next;
    logic signed [cghs_pkg::ACC_W-1:0]  term;
    cghs_pkg::mac_ctrl_t                ctrl_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else begin
            ctrl_reg <= ctrl;
        end
    end

    always_comb begin
        term = cghs_pkg::ACC_W'(prod_reg);
        if (ctrl_reg.shift32) begin
            term = term <<< 32;
        end
        acc_next = acc_reg;
        if (ctrl_reg.acc_load) begin
            acc_next = term;
        end else if (ctrl_reg.acc_add) begin
            acc_next = acc_reg + term;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

[rtl/core/cghs_mem.sv]
// ----------------------------------------------------------------------------
// cghs_mem - per-channel gain and offset stores
// Single-port write, registered read; both read at one address per request.
// ----------------------------------------------------------------------------
module cghs_mem #(
    parameter int CHANNELS = cghs_pkg::CHANNELS_DEFAULT,
    parameter int AW       = 9
) (
    input  logic                                  aclk,
    input  logic                                  rd_en,
    input  logic [AW-1:0]                         rd_addr,
    input  logic                                  gain_we,
    input  logic [AW-1:0]                         gain_addr,
    input  logic signed [cghs_pkg::DATA_W-1:0]    gain_wdata,
    input  logic                                  off_we,
    input  logic [AW-1:0]                         off_addr,
    input  logic signed [cghs_pkg::VALUE_W-1:0]   off_wdata,
    output logic signed [cghs_pkg::DATA_W-1:0]    gain_rdata,
    output logic signed [cghs_pkg::VALUE_W-1:0]   off_rdata
);

    logic signed [cghs_pkg::DATA_W-1:0]  gain_mem [CHANNELS];
    logic signed [cghs_pkg::VALUE_W-1:0] off_mem  [CHANNELS];

    always_ff @(posedge aclk) begin
        if (gain_we) begin
            gain_mem[gain_addr] <= gain_wdata;
        end
        if (rd_en) begin
            gain_rdata <= gain_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (off_we) begin
            off_mem[off_addr] <= off_wdata;
        end
        if (rd_en) begin
            off_rdata <= off_mem[rd_addr];
        end
    end

endmodule

[rtl/core/cghs_outconv.sv]
// ----------------------------------------------------------------------------
// cghs_outconv - Q.24 to integer output conversion
// 16-bit mode truncates toward zero and clamps to +-32767; 32-bit mode
// floors and saturates to the int32 range.
// ----------------------------------------------------------------------------
module cghs_outconv (
    input  logic                                  mode,
    input  logic signed [cghs_pkg::VALUE_W-1:0]   value,
    output logic signed [cghs_pkg::DATA_W-1:0]    result
);

    localparam int IW = cghs_pkg::VALUE_W - cghs_pkg::FRAC_BITS;
    localparam logic signed [IW-1:0] LIM16_HI = IW'(cghs_pkg::MAX16);
    localparam logic signed [IW-1:0] LIM16_LO = -LIM16_HI;
    localparam logic signed [IW-1:0] LIM32_HI = IW'(64'h7FFF_FFFF);
    localparam logic signed [IW-1:0] LIM32_LO = -LIM32_HI - IW'(1);

    logic signed [IW-1:0] floor_v;
    logic signed [IW-1:0] trunc_v;
    logic                 round_up;

    always_comb begin
        floor_v  = value[cghs_pkg::VALUE_W-1:cghs_pkg::FRAC_BITS];
        // a negative value with a fraction moves one step back toward zero
        round_up = value[cghs_pkg::VALUE_W-1] && (|value[cghs_pkg::FRAC_BITS-1:0]);
        trunc_v  = floor_v + IW'(round_up);
        case (mode)
            cghs_pkg::MODE_16: begin
                if (trunc_v > LIM16_HI) begin
                    result = cghs_pkg::DATA_W'(LIM16_HI);
                end else if (trunc_v < LIM16_LO) begin
                    result = cghs_pkg::DATA_W'(LIM16_LO);
                end else begin
                    result = trunc_v[cghs_pkg::DATA_W-1:0];
                end
            end
            default: begin
                if (floor_v > LIM32_HI) begin
                    result = LIM32_HI[cghs_pkg::DATA_W-1:0];
                end else if (floor_v < LIM32_LO) begin
                    result = LIM32_LO[cghs_pkg::DATA_W-1:0];
                end else begin
                    result = floor_v[cghs_pkg::DATA_W-1:0];
                end
            end
        endcase
    end

endmodule

[rtl/core/channel_gain_highpass_scaler.sv]
// ----------------------------------------------------------------------------
// channel_gain_highpass_scaler - per-channel gain with high-pass offset removal
// Gain write: stored as taken; the sequencer stays idle. Sample: LOAD, SCALE, CONV
// to the output register with high-pass off; LOAD, SCALE, P1-P3, SUM, SUB, CONV
// with it on; the next request is taken only back in IDLE. One shared multiplier
// does the gain product and four partials. A waiting result stalls the sequencer.
// Reset: synchronous; the offset store is cleared one entry per cycle over all
// entries, during which no request is taken (config writes still are).
// ----------------------------------------------------------------------------
module channel_gain_highpass_scaler #(
    parameter int CHANNELS = cghs_pkg::CHANNELS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  cghs_pkg::in_item_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output cghs_pkg::out_item_t                m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cghs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cghs_pkg::DECAY_W-1:0]       cfg_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EW = cghs_pkg::CH_W + AW;
    localparam int VW = cghs_pkg::VALUE_W;
    localparam int FB = cghs_pkg::FRAC_BITS;
    localparam logic [cghs_pkg::DECAY_W:0] ONE_Q24 = (cghs_pkg::DECAY_W + 1)'(1) << FB;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_LOAD  = 10'b0000000100,
        S_SCALE = 10'b0000001000,
        S_P1    = 10'b0000010000,
        S_P2    = 10'b0000100000,
        S_P3    = 10'b0001000000,
        S_SUM   = 10'b0010000000,
        S_SUB   = 10'b0100000000,
        S_CONV  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [cghs_pkg::DECAY_W-1:0] decay_reg;
    logic                         hp_en_reg;
    logic                         mode_reg;

    // item context
    logic [cghs_pkg::CH_W-1:0]          chan_reg;
    logic [AW-1:0]                      addr_reg;
    logic                               in_range_reg;
    logic signed [cghs_pkg::DATA_W-1:0] sample_reg;
    logic signed [VW-1:0]               value_reg;
    logic signed [VW-1:0]               filt_reg;
    logic [AW-1:0]                      clr_cnt_reg;

    logic                               m_valid_reg;
    cghs_pkg::out_item_t                m_data_reg;

    logic                               s_accept;
    logic [EW-1:0]                      s_ch_ext;
    logic [AW-1:0]                      s_addr;
    logic                               s_in_range;
    logic                               out_load;

    logic signed [cghs_pkg::DATA_W-1:0]  gain_q;
    logic signed [VW-1:0]                off_q;
    logic                                off_we;
    logic [AW-1:0]                       off_addr;
    logic signed [VW-1:0]                off_wdata;
    logic signed [VW-1:0]                new_off;

    logic signed [cghs_pkg::MUL_W-1:0]   mac_a;
    logic signed [cghs_pkg::MUL_W-1:0]   mac_b;
    cghs_pkg::mac_ctrl_t                 mac_ctrl;
    logic signed [cghs_pkg::PROD_W-1:0]  mac_prod;
    logic signed [cghs_pkg::ACC_W-1:0]   mac_acc;

    logic [cghs_pkg::DECAY_W:0]          keep_q24;
    logic signed [cghs_pkg::MUL_W-1:0]   decay_op;
    logic signed [cghs_pkg::MUL_W-1:0]   keep_op;
    logic signed [cghs_pkg::DATA_W-1:0]  conv_out;

    assign s_ready    = (state_reg == S_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign s_ch_ext   = EW'(s_data.channel);
    assign s_addr     = s_ch_ext[AW-1:0];
    assign s_in_range = s_ch_ext < EW'(CHANNELS);
    assign cfg_ready  = 1'b1;
    assign out_load   = (state_reg == S_CONV) && (!m_valid_reg || m_ready);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg <= cghs_pkg::DECAY_RESET;
            hp_en_reg <= 1'b0;
            mode_reg  <= cghs_pkg::MODE_32;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                cghs_pkg::CFG_DECAY:      decay_reg <= cfg_data;
                cghs_pkg::CFG_HP_ENABLE:  hp_en_reg <= cfg_data[0];
                cghs_pkg::CFG_WIDTH_MODE: mode_reg  <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_cnt_reg == AW'(CHANNELS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept && (s_data.op == cghs_pkg::OP_SAMPLE)) begin
                    state_next = s_in_range ? S_LOAD : S_CONV;
                end
            end
            S_LOAD:  state_next = S_SCALE;
            S_SCALE: state_next = hp_en_reg ? S_P1 : S_CONV;
            S_P1:    state_next = S_P2;
            S_P2:    state_next = S_P3;
            S_P3:    state_next = S_SUM;
            S_SUM:   state_next = S_SUB;
            S_SUB:   state_next = S_CONV;
            S_CONV: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    // operand selection for the shared multiplier
    assign keep_q24 = ONE_Q24 - {1'b0, decay_reg};
    assign decay_op = cghs_pkg::MUL_W'(decay_reg);
    assign keep_op  = cghs_pkg::MUL_W'(keep_q24);

    always_comb begin
        mac_a    = '0;
        mac_b    = '0;
        mac_ctrl = '0;
        case (state_reg)
            S_LOAD: begin
                mac_a = {sample_reg[cghs_pkg::DATA_W-1], sample_reg};
                mac_b = {gain_q[cghs_pkg::DATA_W-1], gain_q};
            end
            S_SCALE: begin
                mac_a             = {1'b0, off_q[31:0]};
                mac_b             = decay_op;
                mac_ctrl.acc_load = hp_en_reg;
            end
            S_P1: begin
                mac_a            = {off_q[VW-1], off_q[VW-1:32]};
                mac_b            = decay_op;
                mac_ctrl.acc_add = 1'b1;
                mac_ctrl.shift32 = 1'b1;
            end
            S_P2: begin
                mac_a            = {1'b0, value_reg[31:0]};
                mac_b            = keep_op;
                mac_ctrl.acc_add = 1'b1;
            end
            S_P3: begin
                mac_a            = {value_reg[VW-1], value_reg[VW-1:32]};
                mac_b            = keep_op;
                mac_ctrl.acc_add = 1'b1;
                mac_ctrl.shift32 = 1'b1;
            end
            default: begin
            end
        endcase
    end

    cghs_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op_a    (mac_a),
        .op_b    (mac_b),
        .ctrl    (mac_ctrl),
        .prod    (mac_prod),
        .acc     (mac_acc)
    );

    assign new_off   = mac_acc[FB+VW-1:FB];
    assign off_we    = (state_reg == S_CLEAR) || (state_reg == S_SUB);
    assign off_addr  = (state_reg == S_CLEAR) ? clr_cnt_reg : addr_reg;
    assign off_wdata = (state_reg == S_CLEAR) ? '0 : new_off;

    cghs_mem #(
        .CHANNELS (CHANNELS),
        .AW       (AW)
    ) u_mem (
        .aclk       (aclk),
        .rd_en      (s_accept),
        .rd_addr    (s_addr),
        .gain_we    (s_accept && (s_data.op == cghs_pkg::OP_GAIN) && s_in_range),
        .gain_addr  (s_addr),
        .gain_wdata (s_data.gain_value),
        .off_we     (off_we),
        .off_addr   (off_addr),
        .off_wdata  (off_wdata),
        .gain_rdata (gain_q),
        .off_rdata  (off_q)
    );

    // item datapath registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            chan_reg     <= s_data.channel;
            addr_reg     <= s_addr;
            in_range_reg <= s_in_range;
            sample_reg   <= s_data.sample_value;
        end
        if (state_reg == S_SCALE) begin
            value_reg <= mac_prod[VW-1:0];
            filt_reg  <= mac_prod[VW-1:0];
        end
        if (state_reg == S_SUB) begin
            filt_reg <= value_reg - new_off;
        end
    end

    cghs_outconv u_outconv (
        .mode   (mode_reg),
        .value  (filt_reg),
        .result (conv_out)
    );

    // output register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.result_channel <= chan_reg;
            m_data_reg.result_value   <= in_range_reg ? conv_out : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    a_load_from_conv : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_CONV))
        else $error("result raised outside the conversion step");

    a_offset_write : assert property (@(posedge aclk) disable iff (!aresetn)
        (off_we && (state_reg != S_CLEAR)) |-> (hp_en_reg && in_range_reg))
        else $error("offset written without high-pass or for an absent channel");

    a_gain_write_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_data.op == cghs_pkg::OP_GAIN)) |=> (state_reg == S_IDLE))
        else $error("gain request left the sequencer busy");

endmodule

[test/tb_channel_gain_highpass_scaler.sv]
// ----------------------------------------------------------------------------
// tb_channel_gain_highpass_scaler - self-checking bench for the channel scaler
// Drives gain writes and samples over the request channel under random idling
// and back-pressure, predicts every scaled result in bit-exact fixed point and
// compares it field by field, through a series of decay, high-pass and output
// width settings.
// ----------------------------------------------------------------------------
module tb_channel_gain_highpass_scaler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS     = cghs_pkg::CHANNELS_DEFAULT;
    localparam int CLK_PERIOD   = 20;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_CYCLES = 200000;

    localparam logic signed [cghs_pkg::DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [cghs_pkg::DATA_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [cghs_pkg::DATA_W-1:0] EXTREME_SAMPLES [5] =
        '{S32_MAX, S32_MIN, 32'sd0, -32'sd1, 32'sd1};

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    cghs_pkg::in_item_t              s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    cghs_pkg::out_item_t             m_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [cghs_pkg::CFG_IDX_W-1:0]  cfg_index = cghs_pkg::CFG_DECAY;
    logic [cghs_pkg::DECAY_W-1:0]    cfg_data  = '0;

    // predictor copy of the block's settings and stores
    logic [cghs_pkg::DECAY_W-1:0]        decay_q24  = cghs_pkg::DECAY_RESET;
    logic                                hp_on      = 1'b0;
    logic                                width_mode = cghs_pkg::MODE_32;
    logic signed [cghs_pkg::DATA_W-1:0]  gain_q824  [CHANNELS];
    logic signed [cghs_pkg::VALUE_W-1:0] offset_q24 [CHANNELS];
    bit                                  gain_known [CHANNELS];
    int                                  gained_channels[$];

    cghs_pkg::out_item_t scaled_outputs_due[$];

    int fail_count    = 0;
    bit src_gaps_on   = 1'b1;
    bit sink_gaps_on  = 1'b1;
    int sink_hold_req = 0;

    channel_gain_highpass_scaler #(
        .CHANNELS(CHANNELS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #(CLK_PERIOD / 2) aclk = 1'b1;
        #(CLK_PERIOD / 2) aclk = 1'b0;
    end

    // Apply one accepted request to the predictor; queue the result of a sample.
    function automatic void predict_scaled_output(input cghs_pkg::in_item_t it);
        logic signed [cghs_pkg::VALUE_W-1:0] sample64;
        logic signed [cghs_pkg::VALUE_W-1:0] gain64;
        logic signed [cghs_pkg::VALUE_W-1:0] filtered;
        logic signed [cghs_pkg::VALUE_W-1:0] new_off;
        logic signed [127:0]                 off_w;
        logic signed [127:0]                 val_w;
        logic signed [127:0]                 d_w;
        logic signed [127:0]                 k_w;
        logic signed [127:0]                 mix;
        logic [cghs_pkg::VALUE_W-1:0]        mag;
        logic [cghs_pkg::VALUE_W-1:0]        q;
        cghs_pkg::out_item_t                 res;
        if (it.op == cghs_pkg::OP_GAIN) begin
            gain_q824[it.channel] = it.gain_value;
            if (!gain_known[it.channel]) begin
                gain_known[it.channel] = 1'b1;
                gained_channels = {gained_channels, int'(it.channel)};
            end
            return;
        end
        sample64 = it.sample_value;
        gain64   = gain_q824[it.channel];
        filtered = sample64 * gain64;
        if (hp_on) begin
            off_w   = offset_q24[it.channel];
            val_w   = filtered;
            d_w     = {104'd0, decay_q24};
            k_w     = (128'sd1 <<< cghs_pkg::FRAC_BITS) - d_w;
            mix     = off_w * d_w + val_w * k_w;
            new_off = mix[cghs_pkg::FRAC_BITS +: cghs_pkg::VALUE_W];
            offset_q24[it.channel] = new_off;
            filtered = filtered - new_off;
        end
        mag = filtered[cghs_pkg::VALUE_W-1] ? -filtered : filtered;
        if (width_mode == cghs_pkg::MODE_16) begin
            q = mag >> cghs_pkg::FRAC_BITS;
            if (q > 64'(cghs_pkg::MAX16)) q = 64'(cghs_pkg::MAX16);
        end else if (!filtered[cghs_pkg::VALUE_W-1]) begin
            q = mag >> cghs_pkg::FRAC_BITS;
            if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        end else begin
            // flooring a negative value rounds its magnitude up
            q = (mag + 64'hFF_FFFF) >> cghs_pkg::FRAC_BITS;
            if (q > 64'h8000_0000) q = 64'h8000_0000;
        end
        res.result_channel = it.channel;
        res.result_value   = filtered[cghs_pkg::VALUE_W-1] ? -q[cghs_pkg::DATA_W-1:0]
                                                           : q[cghs_pkg::DATA_W-1:0];
        scaled_outputs_due = {scaled_outputs_due, res};
    endfunction

    // Samples only ever address channels whose gain has been written.
    function automatic cghs_pkg::in_item_t rand_item();
        cghs_pkg::in_item_t it;
        int                 n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: it.sample_value = $urandom;
            4:          it.sample_value = EXTREME_SAMPLES[$urandom_range(0, 4)];
            default:    it.sample_value = $signed($urandom_range(0, 80000)) - 40000;
        endcase
        case ($urandom_range(0, 3))
            0:       it.gain_value = $urandom;
            default: it.gain_value = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
        endcase
        n = gained_channels.size();
        if (n < 8 || $urandom_range(0, 3) == 0) begin
            it.op      = cghs_pkg::OP_GAIN;
            it.channel = cghs_pkg::CH_W'($urandom_range(0, CHANNELS - 1));
        end else begin
            it.op = cghs_pkg::OP_SAMPLE;
            // favour a few channels so their offsets build up over many samples
            if ($urandom_range(0, 1))
                it.channel = cghs_pkg::CH_W'(gained_channels[$urandom_range(0, 7)]);
            else
                it.channel = cghs_pkg::CH_W'(gained_channels[$urandom_range(0, n - 1)]);
        end
        return it;
    endfunction

    task automatic send_item(input cghs_pkg::in_item_t it);
        int gap;
        gap = src_gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_scaled_output(it);
    endtask

    task automatic send_gain(input int ch, input logic signed [cghs_pkg::DATA_W-1:0] gain);
        cghs_pkg::in_item_t it;
        it.op           = cghs_pkg::OP_GAIN;
        it.channel      = cghs_pkg::CH_W'(ch);
        it.gain_value   = gain;
        it.sample_value = $urandom;
        send_item(it);
    endtask

    task automatic send_sample(input int ch, input logic signed [cghs_pkg::DATA_W-1:0] value);
        cghs_pkg::in_item_t it;
        it.op           = cghs_pkg::OP_SAMPLE;
        it.channel      = cghs_pkg::CH_W'(ch);
        it.sample_value = value;
        it.gain_value   = $urandom;
        send_item(it);
    endtask

    // Hold the source until every queued result is out, then let the block settle.
    task automatic wait_drained();
        if (s_valid) s_valid <= 1'b0;
        while (scaled_outputs_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [cghs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cghs_pkg::DECAY_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            cghs_pkg::CFG_DECAY:      decay_q24  = value;
            cghs_pkg::CFG_HP_ENABLE:  hp_on      = value[0];
            cghs_pkg::CFG_WIDTH_MODE: width_mode = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [cghs_pkg::DECAY_W-1:0] decay, input logic hp,
                              input logic mode);
        wait_drained();
        write_reg(cghs_pkg::CFG_DECAY, decay);
        write_reg(cghs_pkg::CFG_HP_ENABLE, cghs_pkg::DECAY_W'(hp));
        write_reg(cghs_pkg::CFG_WIDTH_MODE, cghs_pkg::DECAY_W'(mode));
        cfg_valid <= 1'b0;
    endtask

    // Reset settings: 32-bit output, high-pass off.
    task automatic test_scaling_32();
        send_gain(0, 32'sh0100_0000);
        send_gain(511, S32_MAX);
        send_gain(256, S32_MIN);
        send_gain(170, -32'sh0100_0000);
        send_gain(341, 32'sh0000_0001);
        send_gain(85, 32'sd0);
        send_sample(0, S32_MAX);
        send_sample(0, S32_MIN);
        send_sample(0, -32'sd1);
        send_sample(0, 32'sd0);
        send_sample(511, S32_MAX);
        send_sample(511, S32_MIN);
        send_sample(256, S32_MIN);
        send_sample(256, 32'sd1);
        send_sample(170, -32'sd3);
        send_sample(341, -32'sd1);
        send_sample(341, 32'sd1);
        send_sample(85, 32'sd12345);
        wait_drained();
    endtask

    task automatic test_clamp_16();
        set_config(cghs_pkg::DECAY_RESET, 1'b0, cghs_pkg::MODE_16);
        send_sample(0, 32'sd40000);
        send_sample(0, -32'sd40000);
        send_sample(341, -32'sd1);
        send_sample(256, S32_MIN);
        send_sample(170, 32'sd32767);
        send_sample(511, -32'sd1);
        wait_drained();
    endtask

    task automatic test_highpass();
        // zero decay: the offset tracks the value and the output is zero
        set_config('0, 1'b1, cghs_pkg::MODE_32);
        send_gain(10, 32'sh0280_0000);
        send_sample(10, 32'sd1000);
        send_sample(10, -32'sd5000);
        send_sample(0, S32_MIN);
        set_config(24'hFF_FFFF, 1'b1, cghs_pkg::MODE_16);
        repeat (6) send_sample(10, 32'sd10000);
        send_sample(511, S32_MAX);
        send_sample(511, S32_MIN);
        // offset must hold while the filter is off
        set_config(24'hFF_FFFF, 1'b0, cghs_pkg::MODE_32);
        send_sample(10, 32'sd10000);
        set_config(cghs_pkg::DECAY_RESET, 1'b1, cghs_pkg::MODE_32);
        repeat (4) send_sample(10, 32'sd10000);
        wait_drained();
    endtask

    // Stall the output long enough for the block to back up into the source.
    task automatic test_output_stall();
        set_config(24'h80_0000, 1'b1, cghs_pkg::MODE_32);
        src_gaps_on   = 1'b0;
        sink_hold_req = 300;
        repeat (40) send_item(rand_item());
        wait_drained();
        src_gaps_on = 1'b1;
    endtask

    task automatic test_random_phases();
        logic [cghs_pkg::DECAY_W-1:0] decay;
        for (int i = 0; i < 8; i++) begin
            case (i % 4)
                0:       decay = '0;
                1:       decay = 24'hFF_FFFF;
                2:       decay = cghs_pkg::DECAY_W'($urandom);
                default: decay = cghs_pkg::DECAY_W'($urandom_range(24'hFF_0000, 24'hFF_FFFF));
            endcase
            set_config(decay, i[0], i[1]);
            src_gaps_on  = (i % 3) != 0;
            sink_gaps_on = (i % 4) != 1;
            repeat (170) send_item(rand_item());
        end
        wait_drained();
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
    endtask

    // Result sink: random ready gaps, long hold on request, compare in order.
    initial begin
        int                  wait_left;
        int                  hold_left;
        bit                  took;
        cghs_pkg::out_item_t want;
        wait_left = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            took = m_valid && m_ready;
            if (took) begin
                if (scaled_outputs_due.size() == 0) begin
                    fail_count++;
                    $display("%0t unexpected result: channel %0d value %0d",
                             $time, m_data.result_channel, m_data.result_value);
                end else begin
                    want = scaled_outputs_due.pop_front();
                    if (want.result_channel !== m_data.result_channel) begin
                        fail_count++;
                        $display("%0t result_channel mismatch: expected %0d, actual %0d",
                                 $time, want.result_channel, m_data.result_channel);
                    end
                    if (want.result_value !== m_data.result_value) begin
                        fail_count++;
                        $display("%0t result_value mismatch: expected %0d, actual %0d",
                                 $time, want.result_value, m_data.result_value);
                    end
                end
                wait_left = sink_gaps_on ? $urandom_range(0, 5) : 0;
            end
            if (sink_hold_req > 0) begin
                hold_left     = sink_hold_req;
                sink_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (wait_left > 0) begin
                wait_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        foreach (offset_q24[i]) offset_q24[i] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_scaling_32();
        test_clamp_16();
        test_highpass();
        test_output_stall();
        test_random_phases();
        wait_drained();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("%0t timeout with %0d results outstanding", $time, scaled_outputs_due.size());
        $display("status: fail");
        $finish;
    end

endmodule
